// File: sv/bounded_sequential_list_defines.svh
// assertion macros for the bounded sequential list rtl
// expects clk and rst_n in the scope of each use
`ifndef BOUNDED_SEQUENTIAL_LIST_DEFINES_SVH
`define BOUNDED_SEQUENTIAL_LIST_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BSL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/blsl_pkg.sv
// shared types and constants for the bounded sequential list
// no dependencies
`default_nettype none

package blsl_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int WORD_W      = 32;
    localparam int OP_W        = 3;
    localparam int POS_W       = 6;
    localparam int CNT_OUT_W   = 7;
    localparam int CAP_W       = 7;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // request codes
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // register index (word address)
    localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_LAST,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                 ok;
        logic [WORD_W-1:0]    read_value;
        logic [CNT_OUT_W-1:0] count;
        logic                 full;
        logic                 empty;
    } res_t;

endpackage

`default_nettype wire

// File: sv/blsl_ram.sv
// entry store: one write port, one read port with registered read data
// depends on blsl_pkg for the word width
`default_nettype none

module blsl_ram #(
    parameter int  DEPTH = blsl_pkg::DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [blsl_pkg::WORD_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output      logic [blsl_pkg::WORD_W-1:0] rdata
);

    logic [blsl_pkg::WORD_W-1:0] ram [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= ram[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/blsl_ctrl.sv
// request sequencer: decode, bounds checks, shift loop over the entry store
// depends on blsl_pkg and bounded_sequential_list_defines.svh
`default_nettype none
`include "bounded_sequential_list_defines.svh"

module blsl_ctrl #(
    parameter int  DEPTH = blsl_pkg::DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output      logic                           in_stall,
    input  wire logic [blsl_pkg::OP_W-1:0]      operation,
    input  wire logic [blsl_pkg::POS_W-1:0]     position,
    input  wire logic [blsl_pkg::WORD_W-1:0]    write_value,
    input  wire logic [blsl_pkg::CAP_W-1:0]     cap,
    output      logic                           mem_we,
    output      logic [AW-1:0]                  mem_waddr,
    output      logic [blsl_pkg::WORD_W-1:0]    mem_wdata,
    output      logic                           mem_re,
    output      logic [AW-1:0]                  mem_raddr,
    input  wire logic [blsl_pkg::WORD_W-1:0]    mem_rdata,
    output      logic                           res_valid,
    input  wire logic                           res_take,
    output      blsl_pkg::res_t                 res
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > blsl_pkg::CAP_W) ? CW : blsl_pkg::CAP_W;

    blsl_pkg::state_t state_reg, state_next;
    logic [blsl_pkg::OP_W-1:0]   op_reg, op_next;
    logic                        ok_reg, ok_next;
    logic [blsl_pkg::WORD_W-1:0] val_reg, val_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [CW-1:0]               count_reg, count_next;

    logic [KW-1:0] cap_k, eff_cap, count_k, pos_k;
    logic          full;
    logic [AW-1:0] pos_a, cnt_a;

    // capacity of zero acts as one, above the store depth acts as the depth
    always_comb
    begin
        cap_k = KW'(cap);
        if (cap_k == '0)
        begin
            eff_cap = KW'(1);
        end
        else if (cap_k > KW'(DEPTH))
        begin
            eff_cap = KW'(DEPTH);
        end
        else
        begin
            eff_cap = cap_k;
        end
    end

    assign count_k = KW'(count_reg);
    assign pos_k   = KW'(position);
    assign full    = (count_k >= eff_cap);
    assign pos_a   = AW'(position);
    assign cnt_a   = AW'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blsl_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        ok_reg  <= ok_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
        idx_reg <= idx_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ok_next    = ok_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        in_stall   = (state_reg != blsl_pkg::ST_IDLE);
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        res_valid  = 1'b0;

        case (state_reg)
            blsl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    pos_next   = pos_a;
                    val_next   = write_value;
                    ok_next    = 1'b0;
                    state_next = blsl_pkg::ST_RESULT;
                    case (operation)
                        blsl_pkg::OP_APPEND:
                        begin
                            if (!full)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = cnt_a;
                                mem_wdata  = write_value;
                                count_next = count_reg + CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        blsl_pkg::OP_INSERT:
                        begin
                            if (!full && (pos_k <= count_k))
                            begin
                                ok_next    = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (pos_k == count_k)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = pos_a;
                                    mem_wdata = write_value;
                                end
                                else
                                begin
                                    // walk down from the tail
                                    mem_re     = 1'b1;
                                    mem_raddr  = cnt_a - AW'(1);
                                    idx_next   = cnt_a - AW'(1);
                                    state_next = blsl_pkg::ST_SHIFT;
                                end
                            end
                        end
                        blsl_pkg::OP_DELETE,
                        blsl_pkg::OP_READ:
                        begin
                            if (pos_k < count_k)
                            begin
                                ok_next    = 1'b1;
                                mem_re     = 1'b1;
                                mem_raddr  = pos_a;
                                idx_next   = pos_a;
                                state_next = blsl_pkg::ST_SHIFT;
                                if (operation == blsl_pkg::OP_DELETE)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                            end
                        end
                        blsl_pkg::OP_CLEAR:
                        begin
                            // slots at or above count are never read back
                            ok_next    = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            blsl_pkg::ST_SHIFT:
            begin
                case (op_reg)
                    blsl_pkg::OP_INSERT:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg + AW'(1);
                        mem_wdata = mem_rdata;
                        if (idx_reg == pos_reg)
                        begin
                            state_next = blsl_pkg::ST_LAST;
                        end
                        else
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = idx_reg - AW'(1);
                            idx_next  = idx_reg - AW'(1);
                        end
                    end
                    blsl_pkg::OP_DELETE:
                    begin
                        if (idx_reg == pos_reg)
                        begin
                            val_next = mem_rdata;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_reg - AW'(1);
                            mem_wdata = mem_rdata;
                        end
                        // count already holds the decremented value
                        if (CW'(idx_reg) == count_reg)
                        begin
                            state_next = blsl_pkg::ST_RESULT;
                        end
                        else
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = idx_reg + AW'(1);
                            idx_next  = idx_reg + AW'(1);
                        end
                    end
                    default:
                    begin
                        val_next   = mem_rdata;
                        state_next = blsl_pkg::ST_RESULT;
                    end
                endcase
            end

            blsl_pkg::ST_LAST:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                state_next = blsl_pkg::ST_RESULT;
            end

            blsl_pkg::ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = blsl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = blsl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.ok = ok_reg;
        if (ok_reg && ((op_reg == blsl_pkg::OP_DELETE) || (op_reg == blsl_pkg::OP_READ)))
        begin
            res.read_value = val_reg;
        end
        else
        begin
            res.read_value = '0;
        end
        res.count = blsl_pkg::CNT_OUT_W'(count_reg);
        res.full  = full;
        res.empty = (count_reg == '0);
    end

    `BSL_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH),
        "entry count above store depth")
    `BSL_ASSERT_SAME(a_port_disjoint, mem_we && mem_re, mem_waddr != mem_raddr,
        "shift writes an entry that is read in the same cycle")
    `BSL_ASSERT_SAME(a_shift_fed, state_reg == blsl_pkg::ST_SHIFT, $past(mem_re),
        "shift step without read data issued the cycle before")
    `BSL_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall,
        state_reg != blsl_pkg::ST_IDLE, "accepted beat left sequencer idle")

endmodule

`default_nettype wire

// File: sv/bounded_sequential_list.sv
// Bounded sequential list: an ordered list of signed 32-bit words kept in a
// DEPTH-entry store with one write and one read port (registered read data).
// Requests are append, insert, delete, read and clear; each request beat
// yields exactly one result beat with ok, read_value, count, full_res and
// empty_res. One request is worked at a time. Append, clear, an insert at
// the tail and any refused request go straight to the result; read passes
// through the shift state to collect its word; delete and any other insert
// shift the entries between position and count, one entry per cycle through
// the store ports. A finished result sits in an
// output register, so the next request is taken while the previous result
// is still stalled. The store needs no clearing pass after reset or clear:
// only entries below count are ever read.
// Capacity sits at byte address 0 of the apb port; write it only while idle.
// depends on blsl_pkg, blsl_ctrl, blsl_ram
`default_nettype none

module bounded_sequential_list #(
    parameter int DEPTH = blsl_pkg::DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // apb configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [blsl_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [blsl_pkg::PDATA_W-1:0]      pwdata,
    output      logic [blsl_pkg::PDATA_W-1:0]      prdata,
    output      logic                              pready,
    // request channel
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic [blsl_pkg::OP_W-1:0]         operation,
    input  wire logic [blsl_pkg::POS_W-1:0]        position,
    input  wire logic signed [blsl_pkg::WORD_W-1:0] write_value,
    // result channel
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic                              ok,
    output      logic signed [blsl_pkg::WORD_W-1:0] read_value,
    output      logic [blsl_pkg::CNT_OUT_W-1:0]    count,
    output      logic                              full_res,
    output      logic                              empty_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [blsl_pkg::CAP_W-1:0]     cap_reg, cap_next;
    logic                           cfg_wr;
    logic [blsl_pkg::PADDR_W-3:0]   reg_idx;

    logic                           mem_we, mem_re;
    logic [AW-1:0]                  mem_waddr, mem_raddr;
    logic [blsl_pkg::WORD_W-1:0]    mem_wdata, mem_rdata;

    logic                           res_valid, res_take;
    blsl_pkg::res_t                 res;

    logic                           out_valid_reg, out_valid_next;
    blsl_pkg::res_t                 out_res_reg, out_res_next;

    // ---- configuration register ----
    assign pready  = 1'b1;
    assign reg_idx = paddr[blsl_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_wr && (reg_idx == blsl_pkg::REG_CAPACITY))
        begin
            cap_next = pwdata[blsl_pkg::CAP_W-1:0];
        end
    end

    always_comb
    begin
        if (reg_idx == blsl_pkg::REG_CAPACITY)
        begin
            prdata = blsl_pkg::PDATA_W'(cap_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= blsl_pkg::CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // ---- sequencer and entry store ----
    blsl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .position    (position),
        .write_value (write_value),
        .cap         (cap_reg),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res)
    );

    blsl_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---- result register ----
    // a finished result moves in whenever the register is empty or draining
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_res_next   = out_res_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid  = out_valid_reg;
    assign ok         = out_res_reg.ok;
    assign read_value = out_res_reg.read_value;
    assign count      = out_res_reg.count;
    assign full_res   = out_res_reg.full;
    assign empty_res  = out_res_reg.empty;

endmodule

`default_nettype wire
